### rtl/lzmc_pkg.sv
// ----------------------------------------------------------------------------
// lzmc_pkg
// Shared types and constants for the LZ77 match compressor.
// ----------------------------------------------------------------------------
package lzmc_pkg;

    localparam int RING_AW   = 13;
    localparam int RING_DEPTH = 1 << RING_AW;
    localparam int TOKEN_CAP = 16;
    localparam int MIN_MATCH = 3;
    localparam int LEN_W     = 5;
    localparam int CNT_W     = 14;

    localparam logic REG_WINDOW_SPAN = 1'b0;
    localparam logic REG_MAX_MATCH   = 1'b1;

    // candidate travelling down the compare chain
    typedef struct packed {
        logic               vld;
        logic               alive;
        logic [LEN_W-1:0]   len;
        logic [RING_AW-1:0] off;
    } cand_t;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_DECIDE  = 5'b00010,
        ST_LOAD    = 5'b00100,
        ST_RUN     = 5'b01000,
        ST_RESOLVE = 5'b10000
    } state_t;

endpackage

### rtl/lzmc_cell.sv
// ----------------------------------------------------------------------------
// lzmc_cell
// One compare cell: holds one lookahead byte and extends a candidate match.
// ----------------------------------------------------------------------------
module lzmc_cell
    import lzmc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cand_t      cand_in,
    input  logic [7:0] stream_byte,
    input  logic       active,
    input  logic       load_en,
    input  logic [7:0] target_in,
    output cand_t      cand_out,
    output logic [7:0] target_out
);

    cand_t      cand_reg;
    cand_t      cand_next;
    logic [7:0] target_reg;

    always_comb
    begin
        cand_next = cand_in;
        if (active)
        begin
            if (cand_in.alive && (stream_byte == target_reg))
            begin
                cand_next.len = cand_in.len + LEN_W'(1);
            end
            else
            begin
                cand_next.alive = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg <= '0;
        end
        else
        begin
            cand_reg <= cand_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            target_reg <= target_in;
        end
    end

    assign cand_out   = cand_reg;
    assign target_out = target_reg;

endmodule

### rtl/lz77_match_compressor.sv
// ----------------------------------------------------------------------------
// lz77_match_compressor
// Byte stream in, LZ77 tokens out, searched by a chain of compare cells.
// ----------------------------------------------------------------------------
// Channel  | Dir | Signals                  | Contents
// s_axis   | in  | tdata[7:0], tlast        | data_byte, final_byte
// m_axis   | out | tdata[25:0], tuser,tlast | literal/offset/length, is_match, eos
// cfg      | in  | cfg_we, cfg_index, cfg_data | window_span, max_match
//
// Input beats are taken one at a time; each token is searched by streaming
// history one byte per cycle from the single read port of the history
// ring.
// Reset clears the control state only; the ring needs no clearing pass.
// A token waits in the output register while the next one is searched.
// ----------------------------------------------------------------------------
module lz77_match_compressor
    import lzmc_pkg::*;
#(
    parameter int WINDOW    = 4096,
    parameter int LOOKAHEAD = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] literal_byte, [20:8] match_offset,
                                        // [25:21] match_length
    output logic        m_axis_tuser,   // [0] is_match
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data
);

    localparam int NCELL   = (LOOKAHEAD < TOKEN_CAP) ? LOOKAHEAD : TOKEN_CAP;
    localparam int WIN_CAP = (WINDOW < RING_DEPTH - TOKEN_CAP) ? WINDOW
                                                               : RING_DEPTH - TOKEN_CAP;

    state_t state_reg;
    state_t state_next;

    logic [12:0]        win_cfg_reg;
    logic [LEN_W-1:0]   mm_cfg_reg;
    logic [RING_AW-1:0] wp_reg;
    logic [RING_AW-1:0] cp_reg;
    logic [LEN_W-1:0]   pend_reg;
    logic [RING_AW-1:0] fill_reg;
    logic               final_reg;
    logic [RING_AW-1:0] win_reg;
    logic [LEN_W-1:0]   lim_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [LEN_W-1:0]   best_len_reg;
    logic [RING_AW-1:0] best_off_reg;

    logic               str_vld_reg;
    logic               inj_reg;
    logic [RING_AW-1:0] d_reg;
    logic               ld_vld_reg;

    logic               out_vld_reg;
    logic [31:0]        out_data_reg;
    logic               out_user_reg;
    logic               out_last_reg;

    logic [7:0]         ring_mem [RING_DEPTH];
    logic [7:0]         rdata_reg;
    logic [RING_AW-1:0] raddr;
    logic               in_acc;

    logic [RING_AW-1:0] eff_w;
    logic [LEN_W-1:0]   eff_m;
    logic [LEN_W-1:0]   lim_new;
    logic [CNT_W-1:0]   run_end;
    logic [CNT_W-1:0]   str_end;
    logic               go_resolve;
    logic               take_tok;
    logic               is_m;
    logic [LEN_W-1:0]   adv;
    logic [CNT_W-1:0]   fill_sum;

    cand_t              chain [NCELL+1];
    logic [7:0]         tgt   [NCELL+1];

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        eff_w = (win_cfg_reg == '0) ? RING_AW'(1) : win_cfg_reg;
        if (eff_w > RING_AW'(WIN_CAP))
        begin
            eff_w = RING_AW'(WIN_CAP);
        end
        if (eff_w > fill_reg)
        begin
            eff_w = fill_reg;
        end
        eff_m = mm_cfg_reg;
        if (eff_m > LEN_W'(NCELL))
        begin
            eff_m = LEN_W'(NCELL);
        end
        if (eff_m < LEN_W'(MIN_MATCH))
        begin
            eff_m = LEN_W'(MIN_MATCH);
        end
        lim_new = (eff_m < pend_reg) ? eff_m : pend_reg;
    end

    assign run_end  = CNT_W'(win_reg) + CNT_W'(lim_reg) + CNT_W'(NCELL + 2);
    assign str_end  = CNT_W'(win_reg) + CNT_W'(lim_reg) - CNT_W'(1);
    assign take_tok = !out_vld_reg || m_axis_tready;
    assign is_m     = (best_len_reg >= LEN_W'(MIN_MATCH));
    assign adv      = is_m ? best_len_reg : LEN_W'(1);
    assign fill_sum = CNT_W'(fill_reg) + CNT_W'(adv);
    assign go_resolve = (state_reg == ST_RESOLVE) && take_tok;

    always_comb
    begin
        priority if (state_reg == ST_LOAD)
        begin
            raddr = cp_reg + cnt_reg[RING_AW-1:0];
        end
        else
        begin
            raddr = cp_reg - win_reg + cnt_reg[RING_AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            ring_mem[wp_reg] <= s_axis_tdata;
        end
        rdata_reg <= ring_mem[raddr];
    end

    // compare chain
    always_comb
    begin
        chain[0].vld   = str_vld_reg && inj_reg;
        chain[0].alive = str_vld_reg && inj_reg;
        chain[0].len   = '0;
        chain[0].off   = d_reg;
    end
    assign tgt[NCELL] = rdata_reg;

    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        lzmc_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .cand_in     (chain[k]),
            .stream_byte (rdata_reg),
            .active      (lim_reg > LEN_W'(k)),
            .load_en     (ld_vld_reg),
            .target_in   (tgt[k+1]),
            .cand_out    (chain[k+1]),
            .target_out  (tgt[k])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (final_reg ? (pend_reg != '0) : (pend_reg >= eff_m))
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD:
            begin
                if (cnt_reg == CNT_W'(NCELL))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cnt_reg == run_end)
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                if (take_tok)
                begin
                    state_next = ST_DECIDE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            win_cfg_reg  <= 13'd4096;
            mm_cfg_reg   <= 5'd16;
            wp_reg       <= '0;
            cp_reg       <= '0;
            pend_reg     <= '0;
            fill_reg     <= '0;
            final_reg    <= 1'b0;
            win_reg      <= '0;
            lim_reg      <= '0;
            cnt_reg      <= '0;
            best_len_reg <= '0;
            best_off_reg <= '0;
            str_vld_reg  <= 1'b0;
            inj_reg      <= 1'b0;
            d_reg        <= '0;
            ld_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_WINDOW_SPAN: win_cfg_reg <= cfg_data;
                    REG_MAX_MATCH:   mm_cfg_reg  <= cfg_data[LEN_W-1:0];
                    default:         win_cfg_reg <= win_cfg_reg;
                endcase
            end

            if (in_acc)
            begin
                wp_reg    <= wp_reg + RING_AW'(1);
                pend_reg  <= pend_reg + LEN_W'(1);
                final_reg <= s_axis_tlast;
            end

            ld_vld_reg  <= (state_reg == ST_LOAD) && (cnt_reg < CNT_W'(NCELL));
            str_vld_reg <= (state_reg == ST_RUN) && (cnt_reg < str_end);
            inj_reg     <= (cnt_reg < CNT_W'(win_reg));
            d_reg       <= win_reg - cnt_reg[RING_AW-1:0];

            unique case (state_reg)
                ST_DECIDE:
                begin
                    win_reg      <= eff_w;
                    lim_reg      <= lim_new;
                    cnt_reg      <= '0;
                    best_len_reg <= '0;
                    best_off_reg <= '0;
                    if (final_reg && (pend_reg == '0))
                    begin
                        fill_reg  <= '0;
                        final_reg <= 1'b0;
                    end
                end
                ST_LOAD:
                begin
                    cnt_reg <= (cnt_reg == CNT_W'(NCELL)) ? '0 : cnt_reg + CNT_W'(1);
                end
                ST_RUN:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (chain[NCELL].vld && (chain[NCELL].len > best_len_reg))
                    begin
                        best_len_reg <= chain[NCELL].len;
                        best_off_reg <= chain[NCELL].off;
                    end
                end
                ST_RESOLVE:
                begin
                    if (take_tok)
                    begin
                        cp_reg   <= cp_reg + RING_AW'(adv);
                        pend_reg <= pend_reg - adv;
                        fill_reg <= (fill_sum > CNT_W'(WIN_CAP)) ? RING_AW'(WIN_CAP)
                                                                 : fill_sum[RING_AW-1:0];
                    end
                end
                default:
                begin
                    cnt_reg <= cnt_reg;
                end
            endcase

            if (go_resolve)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go_resolve)
        begin
            out_user_reg <= is_m;
            out_last_reg <= final_reg && (pend_reg == adv);
            out_data_reg <= {6'd0,
                             is_m ? best_len_reg : LEN_W'(0),
                             is_m ? best_off_reg : RING_AW'(0),
                             is_m ? 8'd0 : tgt[0]};
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

    a_ptr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (cp_reg + RING_AW'(pend_reg)) == wp_reg)
        else $error("coding pointer and pending count disagree with write pointer");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= LEN_W'(NCELL))
        else $error("pending count exceeds lookahead");

    a_best_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESOLVE) |-> (best_len_reg <= lim_reg))
        else $error("match longer than limit");

    a_match_len: assert property (@(posedge clk) disable iff (!rst_n)
        go_resolve && is_m |=> (m_axis_tdata[25:21] >= LEN_W'(MIN_MATCH))
                               && (m_axis_tdata[20:8] != '0))
        else $error("match token with bad length or offset");

endmodule
